[sv/rplm_pkg.sv]
package rplm_pkg;

  localparam int LUX_W      = 17;
  localparam int ACCEL_W    = 16;
  localparam int THR_W      = 8;
  localparam int MODE_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes on the configuration port
  localparam cfg_idx_t CFG_DARK_LUX     = 3'd0;
  localparam cfg_idx_t CFG_DIM_LUX      = 3'd1;
  localparam cfg_idx_t CFG_MOTION_LEVEL = 3'd2;
  localparam cfg_idx_t CFG_HELD_LEVEL   = 3'd3;
  localparam cfg_idx_t CFG_LIFT_TICKS   = 3'd4;
  localparam cfg_idx_t CFG_STILL_TICKS  = 3'd5;
  localparam cfg_idx_t CFG_LOWER_TICKS  = 3'd6;

  // reset values of the configuration registers
  localparam logic [LUX_W-1:0]          DARK_LUX_RST     = 17'd20;
  localparam logic [LUX_W-1:0]          DIM_LUX_RST      = 17'd80;
  localparam logic signed [ACCEL_W-1:0] MOTION_LEVEL_RST = 16'sd5;
  localparam logic signed [ACCEL_W-1:0] HELD_LEVEL_RST   = 16'sd25;
  localparam logic [THR_W-1:0]          LIFT_TICKS_RST   = 8'd3;
  localparam logic [THR_W-1:0]          STILL_TICKS_RST  = 8'd40;
  localparam logic [THR_W-1:0]          LOWER_TICKS_RST  = 8'd5;

endpackage

[sv/robot_pickup_and_light_mode_fsm_core.sv]
// channel  valid      stall      payload
// -------  ---------  ---------  ------------------------------------------------
// in       in_valid   in_stall   light_lux, bump_pressed, accel_z
// out      out_valid  out_stall  mode_now, drive_normal, drive_stop, red_led
// cfg      cfg_wr_en  (none)     cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low; each result passes through
// the input register, then the mode/counter update into the result register.
// Synchronous active-high rst returns mode to measure, counter to zero, normal
// flag to one and all configuration registers to their defaults.
// A stalled result holds; the input register still takes one request behind it,
// after which in_stall rises until the result is taken.
module robot_pickup_and_light_mode_fsm_core #(
  parameter int COUNT_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [rplm_pkg::LUX_W-1:0]            light_lux,
  input  logic                                  bump_pressed,
  input  logic signed [rplm_pkg::ACCEL_W-1:0]   accel_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [rplm_pkg::MODE_W-1:0]           mode_now,
  output logic                                  drive_normal,
  output logic                                  drive_stop,
  output logic                                  red_led,
  input  logic                                  cfg_wr_en,
  input  logic [rplm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rplm_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int CMP_W = (COUNT_BITS > rplm_pkg::THR_W) ? COUNT_BITS : rplm_pkg::THR_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};
  localparam logic [COUNT_BITS-1:0] COUNT_TWO = {{(COUNT_BITS-2){1'b0}}, 2'b10};

  typedef enum logic [rplm_pkg::MODE_W-1:0] {
    MEASURE     = 4'd0,
    NORMAL      = 4'd1,
    SLOW        = 4'd2,
    HALT        = 4'd3,
    PICK_LIGHT  = 4'd4,
    WAIT_STILL  = 4'd5,
    ARM_LOWER   = 4'd6,
    WAIT_LOWER  = 4'd7,
    ARM_SETTLE  = 4'd8,
    WAIT_SETTLE = 4'd9,
    PICK_DONE   = 4'd10
  } mode_t;

  // configuration
  logic [rplm_pkg::LUX_W-1:0]          dark_lux;
  logic [rplm_pkg::LUX_W-1:0]          dim_lux;
  logic signed [rplm_pkg::ACCEL_W-1:0] motion_level;
  logic signed [rplm_pkg::ACCEL_W-1:0] held_level;
  logic [rplm_pkg::THR_W-1:0]          lift_ticks;
  logic [rplm_pkg::THR_W-1:0]          still_ticks;
  logic [rplm_pkg::THR_W-1:0]          lower_ticks;

  // input register
  logic                                in_full;
  logic [rplm_pkg::LUX_W-1:0]          lux_r;
  logic                                bump_r;
  logic signed [rplm_pkg::ACCEL_W-1:0] accel_r;

  // state
  mode_t                  mode_state, mode_state_next;
  logic [COUNT_BITS-1:0]  tick_count, tick_count_next;
  logic                   normal_flag, normal_flag_next;
  logic                   stop_flag, stop_flag_next;
  logic                   led_flag, led_flag_next;

  logic                   in_take;
  logic                   advance;

  logic                   up_motion;
  logic                   is_still;
  logic [COUNT_BITS-1:0]  cnt_inc;
  logic [COUNT_BITS-1:0]  cnt_dec1;
  logic [COUNT_BITS-1:0]  cnt_dec2;
  logic [CMP_W-1:0]       cnt_cmp;
  logic [CMP_W-1:0]       lift_cmp;
  logic [CMP_W-1:0]       still_cmp;
  logic [CMP_W-1:0]       lower_cmp;

  // move a request into the state update when the result slot is free or draining
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_take) begin
      lux_r   <= light_lux;
      bump_r  <= bump_pressed;
      accel_r <= accel_z;
    end
  end

  assign up_motion = accel_r > motion_level;
  assign is_still  = (accel_r == '0);
  assign cnt_inc   = (tick_count == COUNT_MAX) ? tick_count : tick_count + COUNT_ONE;
  assign cnt_dec1  = (tick_count > COUNT_ONE) ? tick_count - COUNT_ONE : '0;
  assign cnt_dec2  = (tick_count > COUNT_TWO) ? tick_count - COUNT_TWO : '0;

  assign cnt_cmp   = CMP_W'(tick_count_next);
  assign lift_cmp  = CMP_W'(lift_ticks);
  assign still_cmp = CMP_W'(still_ticks);
  assign lower_cmp = CMP_W'(lower_ticks);

  // action of the current mode first
  always_comb begin
    tick_count_next  = tick_count;
    normal_flag_next = normal_flag;
    stop_flag_next   = stop_flag;
    led_flag_next    = led_flag;
    case (mode_state)
      MEASURE:     tick_count_next = up_motion ? cnt_inc : '0;
      NORMAL: begin
        normal_flag_next = 1'b1;
        stop_flag_next   = 1'b0;
      end
      SLOW: begin
        normal_flag_next = 1'b0;
        stop_flag_next   = 1'b0;
      end
      HALT: begin
        normal_flag_next = 1'b0;
        stop_flag_next   = 1'b1;
      end
      PICK_LIGHT: begin
        led_flag_next    = 1'b1;
        normal_flag_next = 1'b0;
        stop_flag_next   = 1'b1;
        tick_count_next  = '0;
      end
      WAIT_STILL:  tick_count_next = is_still ? cnt_inc : cnt_dec1;
      ARM_LOWER:   tick_count_next = '0;
      WAIT_LOWER:  tick_count_next = up_motion ? cnt_inc : cnt_dec1;
      ARM_SETTLE:  tick_count_next = '0;
      WAIT_SETTLE: tick_count_next = is_still ? cnt_inc : cnt_dec2;
      PICK_DONE: begin
        led_flag_next   = 1'b0;
        tick_count_next = '0;
      end
      default: ;
    endcase
  end

  // then the next mode from the updated counter
  always_comb begin
    case (mode_state)
      MEASURE: begin
        if (cnt_cmp > lift_cmp) begin
          mode_state_next = PICK_LIGHT;
        end else if (lux_r < dark_lux || bump_r) begin
          mode_state_next = HALT;
        end else if (lux_r < dim_lux) begin
          mode_state_next = SLOW;
        end else begin
          mode_state_next = NORMAL;
        end
      end
      PICK_LIGHT:  mode_state_next = WAIT_STILL;
      WAIT_STILL:  mode_state_next = (cnt_cmp < still_cmp) ? WAIT_STILL : ARM_LOWER;
      ARM_LOWER:   mode_state_next = WAIT_LOWER;
      WAIT_LOWER: begin
        if (accel_r > held_level || cnt_cmp < lower_cmp) begin
          mode_state_next = WAIT_LOWER;
        end else begin
          mode_state_next = ARM_SETTLE;
        end
      end
      ARM_SETTLE:  mode_state_next = WAIT_SETTLE;
      WAIT_SETTLE: mode_state_next = (cnt_cmp < still_cmp) ? WAIT_SETTLE : PICK_DONE;
      default:     mode_state_next = MEASURE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      out_valid    <= 1'b0;
      mode_state   <= MEASURE;
      tick_count   <= '0;
      normal_flag  <= 1'b1;
      stop_flag    <= 1'b0;
      led_flag     <= 1'b0;
      mode_now     <= '0;
      drive_normal <= 1'b0;
      drive_stop   <= 1'b0;
      red_led      <= 1'b0;
      dark_lux     <= rplm_pkg::DARK_LUX_RST;
      dim_lux      <= rplm_pkg::DIM_LUX_RST;
      motion_level <= rplm_pkg::MOTION_LEVEL_RST;
      held_level   <= rplm_pkg::HELD_LEVEL_RST;
      lift_ticks   <= rplm_pkg::LIFT_TICKS_RST;
      still_ticks  <= rplm_pkg::STILL_TICKS_RST;
      lower_ticks  <= rplm_pkg::LOWER_TICKS_RST;
    end else begin
      if (in_take) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end

      if (advance) begin
        out_valid    <= 1'b1;
        mode_state   <= mode_state_next;
        tick_count   <= tick_count_next;
        normal_flag  <= normal_flag_next;
        stop_flag    <= stop_flag_next;
        led_flag     <= led_flag_next;
        mode_now     <= mode_state_next;
        drive_normal <= normal_flag_next;
        drive_stop   <= stop_flag_next;
        red_led      <= led_flag_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_wr_en) begin
        case (cfg_index)
          rplm_pkg::CFG_DARK_LUX:     dark_lux     <= cfg_data;
          rplm_pkg::CFG_DIM_LUX:      dim_lux      <= cfg_data;
          rplm_pkg::CFG_MOTION_LEVEL: motion_level <= cfg_data[rplm_pkg::ACCEL_W-1:0];
          rplm_pkg::CFG_HELD_LEVEL:   held_level   <= cfg_data[rplm_pkg::ACCEL_W-1:0];
          rplm_pkg::CFG_LIFT_TICKS:   lift_ticks   <= cfg_data[rplm_pkg::THR_W-1:0];
          rplm_pkg::CFG_STILL_TICKS:  still_ticks  <= cfg_data[rplm_pkg::THR_W-1:0];
          rplm_pkg::CFG_LOWER_TICKS:  lower_ticks  <= cfg_data[rplm_pkg::THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

[bench/tb_top.sv]
module tb_top;

  localparam int COUNT_BITS  = 8;
  localparam int COUNT_MAX   = (1 << COUNT_BITS) - 1;
  localparam int LUX_MAX     = (1 << rplm_pkg::LUX_W) - 1;
  localparam int ACCEL_MAX   = (1 << (rplm_pkg::ACCEL_W - 1)) - 1;
  localparam int ACCEL_MIN   = -(1 << (rplm_pkg::ACCEL_W - 1));
  localparam int THR_MAX     = (1 << rplm_pkg::THR_W) - 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_LIMIT = 4000;

  typedef enum logic [rplm_pkg::MODE_W-1:0] {
    M_MEASURE, M_NORMAL, M_SLOW, M_HALT, M_PICKUP, M_STILL_WAIT, M_STILL_DONE,
    M_LOWER_WAIT, M_LOWER_DONE, M_SETTLE_WAIT, M_SETTLE_DONE
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  normal;
    logic  stop;
    logic  led;
  } mode_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [rplm_pkg::LUX_W-1:0] light_lux = '0;
  logic bump_pressed = 1'b0;
  logic signed [rplm_pkg::ACCEL_W-1:0] accel_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [rplm_pkg::MODE_W-1:0] mode_now;
  logic drive_normal;
  logic drive_stop;
  logic red_led;
  logic cfg_wr_en = 1'b0;
  logic [rplm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rplm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // predicted controller state and thresholds
  mode_t cur_mode = M_MEASURE;
  logic [COUNT_BITS-1:0] tick_cnt = '0;
  logic normal_q = 1'b1;
  logic stop_q = 1'b0;
  logic led_q = 1'b0;
  logic [rplm_pkg::LUX_W-1:0] dark_thr = rplm_pkg::DARK_LUX_RST;
  logic [rplm_pkg::LUX_W-1:0] dim_thr = rplm_pkg::DIM_LUX_RST;
  logic signed [rplm_pkg::ACCEL_W-1:0] motion_thr = rplm_pkg::MOTION_LEVEL_RST;
  logic signed [rplm_pkg::ACCEL_W-1:0] held_thr = rplm_pkg::HELD_LEVEL_RST;
  logic [rplm_pkg::THR_W-1:0] lift_thr = rplm_pkg::LIFT_TICKS_RST;
  logic [rplm_pkg::THR_W-1:0] still_thr = rplm_pkg::STILL_TICKS_RST;
  logic [rplm_pkg::THR_W-1:0] lower_thr = rplm_pkg::LOWER_TICKS_RST;

  mode_result_t pending_results[$];
  mode_result_t want;
  int errors = 0;
  int cycle_cnt = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  robot_pickup_and_light_mode_fsm_core #(.COUNT_BITS(COUNT_BITS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .light_lux(light_lux), .bump_pressed(bump_pressed), .accel_z(accel_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .mode_now(mode_now), .drive_normal(drive_normal), .drive_stop(drive_stop),
    .red_led(red_led),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] cnt);
    return (cnt != COUNT_MAX) ? cnt + 1'b1 : cnt;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_dec(input logic [COUNT_BITS-1:0] cnt,
                                                    input int unsigned by);
    return (cnt > by) ? COUNT_BITS'(cnt - by) : '0;
  endfunction

  // apply the current mode's action, then pick the next mode
  function automatic mode_result_t advance_mode(input logic [rplm_pkg::LUX_W-1:0] lux,
                                                input logic bump,
                                                input logic signed [rplm_pkg::ACCEL_W-1:0] az);
    mode_t nxt;
    mode_result_t res;
    case (cur_mode)
      M_MEASURE: tick_cnt = (az > motion_thr) ? sat_inc(tick_cnt) : '0;
      M_NORMAL: begin
        normal_q = 1'b1;
        stop_q = 1'b0;
      end
      M_SLOW: begin
        normal_q = 1'b0;
        stop_q = 1'b0;
      end
      M_HALT: begin
        normal_q = 1'b0;
        stop_q = 1'b1;
      end
      M_PICKUP: begin
        led_q = 1'b1;
        normal_q = 1'b0;
        stop_q = 1'b1;
        tick_cnt = '0;
      end
      M_STILL_WAIT: tick_cnt = (az == 0) ? sat_inc(tick_cnt) : sat_dec(tick_cnt, 1);
      M_STILL_DONE, M_LOWER_DONE: tick_cnt = '0;
      M_LOWER_WAIT: tick_cnt = (az > motion_thr) ? sat_inc(tick_cnt) : sat_dec(tick_cnt, 1);
      M_SETTLE_WAIT: tick_cnt = (az == 0) ? sat_inc(tick_cnt) : sat_dec(tick_cnt, 2);
      M_SETTLE_DONE: begin
        led_q = 1'b0;
        tick_cnt = '0;
      end
      default: ;
    endcase
    case (cur_mode)
      M_MEASURE: begin
        if (tick_cnt > lift_thr) nxt = M_PICKUP;
        else if (lux < dark_thr || bump) nxt = M_HALT;
        else if (lux < dim_thr) nxt = M_SLOW;
        else nxt = M_NORMAL;
      end
      M_PICKUP: nxt = M_STILL_WAIT;
      M_STILL_WAIT: nxt = (tick_cnt < still_thr) ? M_STILL_WAIT : M_STILL_DONE;
      M_STILL_DONE: nxt = M_LOWER_WAIT;
      M_LOWER_WAIT: begin
        nxt = (az > held_thr || tick_cnt < lower_thr) ? M_LOWER_WAIT : M_LOWER_DONE;
      end
      M_LOWER_DONE: nxt = M_SETTLE_WAIT;
      M_SETTLE_WAIT: nxt = (tick_cnt < still_thr) ? M_SETTLE_WAIT : M_SETTLE_DONE;
      default: nxt = M_MEASURE;
    endcase
    cur_mode = nxt;
    res.mode = nxt;
    res.normal = normal_q;
    res.stop = stop_q;
    res.led = led_q;
    return res;
  endfunction

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic logic [rplm_pkg::LUX_W-1:0] pick_light();
    int roll;
    int v;
    roll = $urandom_range(0, 99);
    if (roll < 30) return rplm_pkg::LUX_W'($urandom_range(0, LUX_MAX));
    // hover around the dark and dim thresholds
    v = ((roll < 65) ? int'(dark_thr) : int'(dim_thr)) + rand_between(-2, 2);
    if (v < 0) v = 0;
    if (v > LUX_MAX) v = LUX_MAX;
    return rplm_pkg::LUX_W'(v);
  endfunction

  // steer acceleration by predicted mode so the pick-up sequence gets exercised
  function automatic logic signed [rplm_pkg::ACCEL_W-1:0] pick_accel();
    int roll;
    int lo;
    roll = $urandom_range(0, 99);
    case (cur_mode)
      M_MEASURE: begin
        if (roll < 65 && motion_thr < ACCEL_MAX) begin
          lo = motion_thr + 1;
          if (roll < 45)
            return rplm_pkg::ACCEL_W'(rand_between(lo,
                                                    (lo + 30 > ACCEL_MAX) ? ACCEL_MAX : lo + 30));
          return rplm_pkg::ACCEL_W'(rand_between(lo, ACCEL_MAX));
        end
      end
      M_STILL_WAIT, M_SETTLE_WAIT: begin
        if (roll < 85) return '0;
      end
      M_LOWER_WAIT: begin
        // hold the robot up near the top of the count to hit saturation
        if (tick_cnt >= COUNT_MAX - 1 && roll < 50 && held_thr < ACCEL_MAX)
          return rplm_pkg::ACCEL_W'(rand_between(held_thr + 1, ACCEL_MAX));
        if (roll < 60 && motion_thr < held_thr)
          return rplm_pkg::ACCEL_W'(rand_between(motion_thr + 1, held_thr));
        if (roll < 80) return rplm_pkg::ACCEL_W'(rand_between(ACCEL_MIN, held_thr));
      end
      default: ;
    endcase
    if ($urandom_range(0, 4) == 0) return '0;
    return rplm_pkg::ACCEL_W'($urandom_range(0, 65535));
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    errors++;
  endtask

  task automatic send_tick(input logic [rplm_pkg::LUX_W-1:0] lux, input logic bump,
                           input logic signed [rplm_pkg::ACCEL_W-1:0] az);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    light_lux <= lux;
    bump_pressed <= bump;
    accel_z <= az;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(advance_mode(lux, bump, az));
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input rplm_pkg::cfg_idx_t idx,
                           input logic [rplm_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  task automatic apply_thresholds(input logic [rplm_pkg::LUX_W-1:0] dark,
                                  input logic [rplm_pkg::LUX_W-1:0] dim,
                                  input logic signed [rplm_pkg::ACCEL_W-1:0] motion,
                                  input logic signed [rplm_pkg::ACCEL_W-1:0] held,
                                  input logic [rplm_pkg::THR_W-1:0] lift,
                                  input logic [rplm_pkg::THR_W-1:0] still,
                                  input logic [rplm_pkg::THR_W-1:0] lower);
    drain_results();
    write_reg(rplm_pkg::CFG_DARK_LUX, dark);
    write_reg(rplm_pkg::CFG_DIM_LUX, dim);
    write_reg(rplm_pkg::CFG_MOTION_LEVEL, {1'b0, motion});
    write_reg(rplm_pkg::CFG_HELD_LEVEL, {1'b0, held});
    write_reg(rplm_pkg::CFG_LIFT_TICKS, rplm_pkg::CFG_DATA_W'(lift));
    write_reg(rplm_pkg::CFG_STILL_TICKS, rplm_pkg::CFG_DATA_W'(still));
    write_reg(rplm_pkg::CFG_LOWER_TICKS, rplm_pkg::CFG_DATA_W'(lower));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    dark_thr = dark;
    dim_thr = dim;
    motion_thr = motion;
    held_thr = held;
    lift_thr = lift;
    still_thr = still;
    lower_thr = lower;
  endtask

  task automatic drive_random_ticks(input int n);
    int i;
    logic [rplm_pkg::LUX_W-1:0] lux;
    logic bump;
    logic signed [rplm_pkg::ACCEL_W-1:0] az;
    for (i = 0; i < n; i++) begin
      lux = pick_light();
      bump = ($urandom_range(0, 99) < 15);
      az = pick_accel();
      send_tick(lux, bump, az);
    end
  endtask

  task automatic test_directed();
    apply_thresholds(rplm_pkg::DARK_LUX_RST, rplm_pkg::DIM_LUX_RST,
                     rplm_pkg::MOTION_LEVEL_RST, 16'sd30, rplm_pkg::LIFT_TICKS_RST,
                     8'd2, 8'd2);
    // light and bump edges around the thresholds, accel extremes
    send_tick(17'd0, 1'b0, 16'sd0);
    send_tick(rplm_pkg::LUX_W'(LUX_MAX), 1'b0, rplm_pkg::ACCEL_W'(ACCEL_MIN));
    send_tick(rplm_pkg::LUX_W'(LUX_MAX), 1'b0, rplm_pkg::ACCEL_W'(ACCEL_MAX));
    send_tick(17'd19, 1'b0, 16'sd5);
    send_tick(17'd20, 1'b0, 16'sd5);
    send_tick(17'd79, 1'b1, 16'sd0);
    send_tick(17'd80, 1'b1, 16'sd6);
    send_tick(17'd80, 1'b0, 16'sd0);
    // keep lifting until the count passes the lift threshold
    repeat (5) send_tick(17'd80, 1'b0, 16'sd6);
    send_tick(pick_light(), 1'($urandom_range(0, 1)), rplm_pkg::ACCEL_W'(ACCEL_MAX));
    // still wait with one jolt, clamped at zero
    send_tick(pick_light(), 1'($urandom_range(0, 1)), 16'sd0);
    send_tick(pick_light(), 1'($urandom_range(0, 1)), -16'sd7);
    send_tick(pick_light(), 1'($urandom_range(0, 1)), 16'sd0);
    send_tick(pick_light(), 1'($urandom_range(0, 1)), 16'sd0);
    send_tick(pick_light(), 1'($urandom_range(0, 1)), pick_accel());
    // lowering: above held level keeps waiting
    send_tick(pick_light(), 1'($urandom_range(0, 1)), 16'sd31);
    send_tick(pick_light(), 1'($urandom_range(0, 1)), 16'sd6);
    send_tick(pick_light(), 1'($urandom_range(0, 1)), pick_accel());
    // settle wait with a double decrement from one
    send_tick(pick_light(), 1'($urandom_range(0, 1)), 16'sd0);
    send_tick(pick_light(), 1'($urandom_range(0, 1)), 16'sd3);
    send_tick(pick_light(), 1'($urandom_range(0, 1)), 16'sd0);
    send_tick(pick_light(), 1'($urandom_range(0, 1)), 16'sd0);
    send_tick(pick_light(), 1'($urandom_range(0, 1)), pick_accel());
  endtask

  task automatic test_default_thresholds();
    apply_thresholds(rplm_pkg::DARK_LUX_RST, rplm_pkg::DIM_LUX_RST,
                     rplm_pkg::MOTION_LEVEL_RST, rplm_pkg::HELD_LEVEL_RST,
                     rplm_pkg::LIFT_TICKS_RST, rplm_pkg::STILL_TICKS_RST,
                     rplm_pkg::LOWER_TICKS_RST);
    drive_random_ticks(250);
  endtask

  task automatic test_max_thresholds();
    apply_thresholds(rplm_pkg::LUX_W'(LUX_MAX), rplm_pkg::LUX_W'(LUX_MAX),
                     rplm_pkg::ACCEL_W'(ACCEL_MAX), rplm_pkg::ACCEL_W'(ACCEL_MAX),
                     rplm_pkg::THR_W'(THR_MAX), rplm_pkg::THR_W'(THR_MAX),
                     rplm_pkg::THR_W'(THR_MAX));
    drive_random_ticks(100);
  endtask

  task automatic test_min_thresholds();
    apply_thresholds('0, '0, rplm_pkg::ACCEL_W'(ACCEL_MIN), rplm_pkg::ACCEL_W'(ACCEL_MIN),
                     '0, '0, '0);
    drive_random_ticks(120);
  endtask

  // lowering wait runs the counter up to its ceiling
  task automatic test_count_saturation();
    apply_thresholds(rplm_pkg::DARK_LUX_RST, rplm_pkg::DIM_LUX_RST,
                     rplm_pkg::ACCEL_W'(ACCEL_MIN), -16'sd1, '0, '0,
                     rplm_pkg::THR_W'(THR_MAX));
    drive_random_ticks(300);
  endtask

  task automatic test_random_thresholds();
    int k;
    int v;
    logic [rplm_pkg::LUX_W-1:0] dark;
    logic [rplm_pkg::LUX_W-1:0] dim;
    logic signed [rplm_pkg::ACCEL_W-1:0] motion;
    logic signed [rplm_pkg::ACCEL_W-1:0] held;
    logic [rplm_pkg::THR_W-1:0] lift;
    logic [rplm_pkg::THR_W-1:0] still;
    logic [rplm_pkg::THR_W-1:0] lower;
    for (k = 0; k < 3; k++) begin
      if ($urandom_range(0, 9) == 0) dark = rplm_pkg::LUX_W'($urandom_range(0, LUX_MAX));
      else dark = rplm_pkg::LUX_W'($urandom_range(0, 100));
      v = int'(dark) + int'($urandom_range(0, 100));
      dim = rplm_pkg::LUX_W'((v > LUX_MAX) ? LUX_MAX : v);
      motion = rplm_pkg::ACCEL_W'(rand_between(-20, 20));
      v = int'(motion) + int'($urandom_range(0, 40));
      held = rplm_pkg::ACCEL_W'((v > ACCEL_MAX) ? ACCEL_MAX : v);
      lift = rplm_pkg::THR_W'($urandom_range(0, 6));
      still = rplm_pkg::THR_W'($urandom_range(0, 10));
      lower = rplm_pkg::THR_W'($urandom_range(0, 6));
      apply_thresholds(dark, dim, motion, held, lift, still, lower);
      drive_random_ticks(100);
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (mode_now !== want.mode)
          report_mismatch($sformatf("mode_now %0d, predicted %0d", mode_now, want.mode));
        if (drive_normal !== want.normal)
          report_mismatch($sformatf("drive_normal %b, predicted %b", drive_normal, want.normal));
        if (drive_stop !== want.stop)
          report_mismatch($sformatf("drive_stop %b, predicted %b", drive_stop, want.stop));
        if (red_led !== want.led)
          report_mismatch($sformatf("red_led %b, predicted %b", red_led, want.led));
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk) cycle_cnt++;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    snd_idle_pct = 26;
    rcv_idle_pct = 63;
    test_directed();
    test_default_thresholds();
    snd_idle_pct = 63;
    rcv_idle_pct = 26;
    test_max_thresholds();
    test_min_thresholds();
    test_count_saturation();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_thresholds();
    drain_results();
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d requests never produced a result", pending_results.size()));
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
